// ----- hdl/rmet_pkg.sv -----
// Shared constants and saturation helpers for the rational map escape-time core.
`timescale 1ns / 1ps
package rmet_pkg;

    localparam logic signed [31:0] VMAX = 32'sd2147483647;

    function automatic logic signed [31:0] f_sat64(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = VMAX;
        end else if (v < -64'sd2147483647) begin
            r = -VMAX;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] f_sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v > 33'sd2147483647) begin
            r = VMAX;
        end else if (v < -33'sd2147483647) begin
            r = -VMAX;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] f_sym(input logic [31:0] v);
        logic signed [31:0] r;
        if (v == 32'h8000_0000) begin
            r = -VMAX;
        end else begin
            r = $signed(v);
        end
        return r;
    endfunction

    typedef enum logic [1:0] {
        REG_PARAM_RE = 2'd0,
        REG_PARAM_IM = 2'd1,
        REG_LIMIT    = 2'd2,
        REG_CAP      = 2'd3
    } t_reg;

endpackage

// ----- hdl/rational_map_escape_time_core.sv -----
// Escape-time engine for x <- n/((x-a)(p*x+q)) on one shared multiplier and a serial divider.
// Sequence: setup, then each iteration runs up to 16 multiply and accumulate ops,
//   8 writeback steps, two serial divisions and one check; a final magnitude test or
//   check ends the run, followed by the result beat.
// Throughput: one item at a time; busy stays high until the result beat, set by the
//   iteration count of the point and the single multiplier and divider.
// Reset: synchronous, active low; clears the sequencer and loads the register defaults.
// The result beat is shown for one cycle on o_valid; the receiver cannot stall.
`timescale 1ns / 1ps
module rational_map_escape_time_core
    import rmet_pkg::*;
#(
    parameter int FRAC_BITS  = 24,
    parameter int COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_start_re,
    input  logic [31:0] i_start_im,
    output logic        o_valid,
    output logic        o_escaped,
    output logic [15:0] o_iteration_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int CW = COUNT_BITS;
    localparam int DW = 64 + FRAC_BITS;
    localparam logic signed [63:0] W_ONE = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] W_TWO = 64'sd2 <<< FRAC_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_ACC, S_WB, S_CHECK, S_DIVINIT, S_DIV, S_DONE
    } t_state;

    typedef enum logic [4:0] {
        OP_NRE0, OP_NRE1, OP_NIM0, OP_NIM1, OP_MAG0, OP_MAG1,
        OP_MRE0, OP_MRE1, OP_MIM0, OP_MIM1, OP_DRE0, OP_DRE1,
        OP_DIM0, OP_DIM1, OP_DEN0, OP_DEN1, OP_URE0, OP_URE1,
        OP_UIM0, OP_UIM1
    } t_op;

    t_state r_state;
    t_op    r_op;

    logic [31:0] r_param_re, r_param_im;
    logic [13:0] r_limit;
    logic [15:0] r_cap;

    logic signed [31:0] r_xr, r_xi, r_ar, r_ai, r_am1, r_pr, r_qr, r_qi;
    logic signed [31:0] r_nr, r_ni, r_d1r, r_d1i, r_d2r, r_d2i, r_dr, r_di;
    logic signed [63:0] r_prod, r_acc, r_numr, r_numi;
    logic [63:0]        r_den;
    logic [CW-1:0]      r_i;
    logic               r_forced, r_ovf, r_comp, r_sign;
    logic [64:0]        r_rem;
    logic [30:0]        r_dlo;
    logic [29:0]        r_q;
    logic [4:0]         r_cnt;
    logic               r_valid, r_escaped;
    logic [15:0]        r_count;

    logic signed [31:0] w_opa, w_opb, w_fx, w_ar_s, w_ai_s, w_qres;
    logic               w_neg;
    logic signed [63:0] n_acc, w_num;
    logic [CW-1:0]      w_cap;
    logic [63:0]        w_whole, w_mag;
    logic [DW-1:0]      w_dfull, w_r0;
    logic [64:0]        w_t;
    logic               w_ge, w_dovf;
    logic [30:0]        w_q;

    assign w_cap  = CW'({{CW{1'b0}}, r_cap});
    assign w_ar_s = f_sym(r_param_re);
    assign w_ai_s = f_sym(r_param_im);
    assign w_fx   = f_sat64(r_acc >>> FRAC_BITS);
    assign w_whole = r_acc >> (2 * FRAC_BITS);

    always_comb begin
        w_opa = r_ar;
        w_opb = r_am1;
        w_neg = 1'b0;
        unique case (r_op)
            OP_NRE0: begin w_opa = r_ar;  w_opb = r_am1; end
            OP_NRE1: begin w_opa = r_ai;  w_opb = r_ai;  w_neg = 1'b1; end
            OP_NIM0: begin w_opa = r_ar;  w_opb = r_ai;  end
            OP_NIM1: begin w_opa = r_ai;  w_opb = r_am1; end
            OP_MAG0: begin w_opa = r_xr;  w_opb = r_xr;  end
            OP_MAG1: begin w_opa = r_xi;  w_opb = r_xi;  end
            OP_MRE0: begin w_opa = r_pr;  w_opb = r_xr;  end
            OP_MRE1: begin w_opa = r_ai;  w_opb = r_xi;  w_neg = 1'b1; end
            OP_MIM0: begin w_opa = r_pr;  w_opb = r_xi;  end
            OP_MIM1: begin w_opa = r_ai;  w_opb = r_xr;  end
            OP_DRE0: begin w_opa = r_d1r; w_opb = r_d2r; end
            OP_DRE1: begin w_opa = r_d1i; w_opb = r_d2i; w_neg = 1'b1; end
            OP_DIM0: begin w_opa = r_d1r; w_opb = r_d2i; end
            OP_DIM1: begin w_opa = r_d1i; w_opb = r_d2r; end
            OP_DEN0: begin w_opa = r_dr;  w_opb = r_dr;  end
            OP_DEN1: begin w_opa = r_di;  w_opb = r_di;  end
            OP_URE0: begin w_opa = r_nr;  w_opb = r_dr;  end
            OP_URE1: begin w_opa = r_ni;  w_opb = r_di;  end
            OP_UIM0: begin w_opa = r_ni;  w_opb = r_dr;  end
            OP_UIM1: begin w_opa = r_nr;  w_opb = r_di;  w_neg = 1'b1; end
            default: begin w_opa = r_ar;  w_opb = r_am1; end
        endcase
    end

    always_comb begin
        n_acc = r_op[0] ? r_acc : 64'sd0;
        n_acc = w_neg ? n_acc - r_prod : n_acc + r_prod;
    end

    // divider front end
    assign w_num   = r_comp ? r_numi : r_numr;
    assign w_mag   = w_num[63] ? 64'(-w_num) : 64'(w_num);
    assign w_dfull = DW'(w_mag) << FRAC_BITS;
    assign w_r0    = w_dfull >> 31;
    assign w_dovf  = w_r0 >= DW'(r_den);
    assign w_t     = {r_rem[63:0], r_dlo[30]};
    assign w_ge    = w_t >= {1'b0, r_den};
    assign w_q     = {r_q, w_ge};
    assign w_qres  = r_sign ? -$signed({1'b0, w_q}) : $signed({1'b0, w_q});

    always_ff @(posedge i_clk) begin
        r_valid <= 1'b0;
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_op       <= OP_NRE0;
            r_valid    <= 1'b0;
            r_param_re <= 32'd0;
            r_param_im <= 32'h0100_0000;
            r_limit    <= 14'd10000;
            r_cap      <= 16'd100;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == 8'(REG_PARAM_RE)) r_param_re <= i_cfg_data;
                if (i_cfg_index == 8'(REG_PARAM_IM)) r_param_im <= i_cfg_data;
                if (i_cfg_index == 8'(REG_LIMIT))    r_limit    <= i_cfg_data[13:0];
                if (i_cfg_index == 8'(REG_CAP))      r_cap      <= i_cfg_data[15:0];
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_xr     <= f_sym(i_start_re);
                        r_xi     <= f_sym(i_start_im);
                        r_ar     <= w_ar_s;
                        r_ai     <= w_ai_s;
                        r_am1    <= f_sat64(64'(w_ar_s) - W_ONE);
                        r_pr     <= f_sat64(64'(w_ar_s) - W_TWO);
                        r_qr     <= f_sat64(W_ONE - 64'(w_ar_s));
                        r_qi     <= -w_ai_s;
                        r_i      <= '0;
                        r_forced <= 1'b0;
                        r_op     <= OP_NRE0;
                        r_state  <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= w_opa * w_opb;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc <= n_acc;
                    if (r_op[0]) begin
                        r_state <= S_WB;
                    end else begin
                        r_op    <= t_op'(r_op + 5'd1);
                        r_state <= S_MUL;
                    end
                end
                S_WB: begin
                    r_state <= S_MUL;
                    r_op    <= t_op'(r_op + 5'd1);
                    unique case (r_op)
                        OP_NRE1: r_nr <= w_fx;
                        OP_NIM1: begin
                            r_ni    <= w_fx;
                            r_state <= S_CHECK;
                        end
                        OP_MAG1: begin
                            if (w_whole < {50'd0, r_limit}) begin
                                r_d1r <= f_sat33(33'(r_xr) - 33'(r_ar));
                                r_d1i <= f_sat33(33'(r_xi) - 33'(r_ai));
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                        OP_MRE1: r_d2r <= f_sat33(33'(w_fx) + 33'(r_qr));
                        OP_MIM1: r_d2i <= f_sat33(33'(w_fx) + 33'(r_qi));
                        OP_DRE1: r_dr  <= w_fx;
                        OP_DIM1: r_di  <= w_fx;
                        OP_DEN1: begin
                            if (r_acc == 64'sd0) begin
                                r_xr     <= VMAX;
                                r_xi     <= VMAX;
                                r_forced <= 1'b1;
                                r_i      <= r_i + 1'b1;
                                r_state  <= S_CHECK;
                            end else begin
                                r_den <= r_acc;
                            end
                        end
                        OP_URE1: r_numr <= r_acc;
                        OP_UIM1: begin
                            r_numi  <= r_acc;
                            r_comp  <= 1'b0;
                            r_ovf   <= 1'b0;
                            r_state <= S_DIVINIT;
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_CHECK: begin
                    if ((r_i >= w_cap) || r_forced) begin
                        r_state <= S_DONE;
                    end else begin
                        r_op    <= OP_MAG0;
                        r_state <= S_MUL;
                    end
                end
                S_DIVINIT: begin
                    r_sign <= w_num[63];
                    r_cnt  <= 5'd0;
                    if (w_dovf) begin
                        r_ovf <= 1'b1;
                        if (r_comp) begin
                            r_xi     <= w_num[63] ? -VMAX : VMAX;
                            r_forced <= 1'b1;
                            r_i      <= r_i + 1'b1;
                            r_state  <= S_CHECK;
                        end else begin
                            r_xr   <= w_num[63] ? -VMAX : VMAX;
                            r_comp <= 1'b1;
                        end
                    end else begin
                        r_rem   <= 65'(w_r0);
                        r_dlo   <= w_dfull[30:0];
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= w_ge ? w_t - {1'b0, r_den} : w_t;
                    r_q   <= w_q[29:0];
                    r_dlo <= {r_dlo[29:0], 1'b0};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd30) begin
                        if (r_comp) begin
                            r_xi     <= w_qres;
                            r_forced <= r_ovf;
                            r_i      <= r_i + 1'b1;
                            r_state  <= S_CHECK;
                        end else begin
                            r_xr    <= w_qres;
                            r_comp  <= 1'b1;
                            r_state <= S_DIVINIT;
                        end
                    end
                end
                S_DONE: begin
                    r_valid   <= 1'b1;
                    r_escaped <= r_i < w_cap;
                    r_count   <= (r_i < w_cap) ? 16'({16'd0, r_i}) : 16'd0;
                    r_state   <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy              = r_state != S_IDLE;
    assign o_valid           = r_valid;
    assign o_escaped         = r_escaped;
    assign o_iteration_count = r_count;
    assign o_cfg_ready       = 1'b1;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_beat_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result beat while busy");

    a_beat_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result beat longer than one cycle");

    a_bounded_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_escaped) |-> (o_iteration_count == 16'd0))
        else $error("bounded point with nonzero count");

endmodule
